### src/sicm_pkg.sv
// ----------------------------------------------------------------------------
// sicm_pkg
// Shared types and constants for the sorted interval cluster merge unit.
// ----------------------------------------------------------------------------
package sicm_pkg;

    localparam int unsigned COORD_W   = 31;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned COUNT_W   = 21;
    localparam int unsigned FIRST_W   = 20;
    localparam int unsigned THR_W     = 16;

    // Stream index wraps at this many items.
    localparam int unsigned MAX_ITEMS = 1048576;
    localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);

    // Result queue between the merge core and the output port.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned LEVEL_W    = $clog2(FIFO_DEPTH + 1);

    // Signed width that holds read_length + read_from - read_to - 1.
    localparam int unsigned DIFF_W = POS_W + 3;

    typedef struct packed {
        logic [COORD_W-1:0] ref_start;
        logic [COORD_W-1:0] ref_stop;
        logic [POS_W-1:0]   read_from;
        logic [POS_W-1:0]   read_to;
        logic [POS_W-1:0]   read_length;
        logic               is_three_prime;
        logic               last_item;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] region_start;
        logic [COORD_W-1:0] region_stop;
        logic [COUNT_W-1:0] members;
        logic [COUNT_W-1:0] three_prime_members;
        logic [COUNT_W-1:0] five_prime_members;
        logic [COUNT_W-1:0] major_members;
        logic [FIRST_W-1:0] first_index;
        logic               final_cluster;
    } result_t;

    // Up to two results produced by one item, in order of delivery.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
        return r;
    endfunction

endpackage

### src/sicm_cluster_core.sv
// ----------------------------------------------------------------------------
// sicm_cluster_core
// Input register, running cluster state and the merge decision for one item.
// ----------------------------------------------------------------------------
module sicm_cluster_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sicm_pkg::item_t             in_data,
    input  logic [sicm_pkg::THR_W-1:0]  min_trigger_len,
    input  logic                        room,
    output sicm_pkg::push_t             push
);
    import sicm_pkg::*;

    logic               held_reg;
    item_t              item_reg;

    logic               open_reg,  open_next;
    logic [COORD_W-1:0] begin_reg, begin_next;
    logic [COORD_W-1:0] end_reg,   end_next;
    logic [COUNT_W-1:0] mem_reg,   mem_next;
    logic [COUNT_W-1:0] three_reg, three_next;
    logic [COUNT_W-1:0] five_reg,  five_next;
    logic [COUNT_W-1:0] major_reg, major_next;
    logic [IDX_W-1:0]   first_reg, first_next;
    logic [IDX_W-1:0]   cnt_reg,   cnt_next;

    logic                     fire;
    logic signed [DIFF_W-1:0] unaligned;
    logic                     major;
    logic                     gap;
    logic                     join_open;
    result_t                  old_res;
    result_t                  new_res;

    assign fire     = held_reg && room;
    assign in_ready = !held_reg || fire;

    // read_length - (read_to - read_from + 1)
    assign unaligned = signed'(DIFF_W'(item_reg.read_length))
                     + signed'(DIFF_W'(item_reg.read_from))
                     - signed'(DIFF_W'(item_reg.read_to))
                     - signed'(DIFF_W'(1));
    assign major     = unaligned >= signed'(DIFF_W'(min_trigger_len));

    assign gap       = open_reg && (item_reg.ref_start > end_reg);
    assign join_open = open_reg && !gap;

    always_comb begin
        if (join_open) begin
            begin_next = begin_reg;
            end_next   = (item_reg.ref_stop > end_reg) ? item_reg.ref_stop : end_reg;
            mem_next   = sat_inc(mem_reg);
            three_next = item_reg.is_three_prime ? sat_inc(three_reg) : three_reg;
            five_next  = item_reg.is_three_prime ? five_reg : sat_inc(five_reg);
            major_next = major ? sat_inc(major_reg) : major_reg;
            first_next = first_reg;
        end else begin
            begin_next = item_reg.ref_start;
            end_next   = item_reg.ref_stop;
            mem_next   = COUNT_W'(1);
            three_next = COUNT_W'(item_reg.is_three_prime);
            five_next  = COUNT_W'(!item_reg.is_three_prime);
            major_next = COUNT_W'(major);
            first_next = cnt_reg;
        end
        open_next = !item_reg.last_item;
        if (item_reg.last_item || (cnt_reg == IDX_W'(MAX_ITEMS - 1))) begin
            cnt_next = '0;
        end else begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    always_comb begin
        old_res.region_start        = begin_reg;
        old_res.region_stop         = end_reg;
        old_res.members             = mem_reg;
        old_res.three_prime_members = three_reg;
        old_res.five_prime_members  = five_reg;
        old_res.major_members       = major_reg;
        old_res.first_index         = FIRST_W'(first_reg);
        old_res.final_cluster       = 1'b0;

        new_res.region_start        = begin_next;
        new_res.region_stop         = end_next;
        new_res.members             = mem_next;
        new_res.three_prime_members = three_next;
        new_res.five_prime_members  = five_next;
        new_res.major_members       = major_next;
        new_res.first_index         = FIRST_W'(first_next);
        new_res.final_cluster       = 1'b1;

        // closed cluster goes first, the final one after it
        push.res0 = gap ? old_res : new_res;
        push.res1 = new_res;
        if (!fire) begin
            push.cnt = 2'd0;
        end else begin
            push.cnt = 2'(gap) + 2'(item_reg.last_item);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
            open_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (in_ready) begin
                held_reg <= in_valid;
            end
            if (fire) begin
                open_reg <= open_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_data;
        end
        if (fire) begin
            begin_reg <= begin_next;
            end_reg   <= end_next;
            mem_reg   <= mem_next;
            three_reg <= three_next;
            five_reg  <= five_next;
            major_reg <= major_next;
            first_reg <= first_next;
        end
    end

endmodule

### src/sicm_result_fifo.sv
// ----------------------------------------------------------------------------
// sicm_result_fifo
// Small result queue: takes up to two results a cycle, delivers one while out_ready is high.
// ----------------------------------------------------------------------------
module sicm_result_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sicm_pkg::push_t               push,
    output logic                          room,
    output logic [sicm_pkg::LEVEL_W-1:0]  level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sicm_pkg::result_t             out_data
);
    import sicm_pkg::*;

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_second;

    assign room      = level_reg <= LEVEL_W'(FIFO_DEPTH - 2);
    assign level     = level_reg;
    assign out_valid = level_reg != '0;
    assign out_data  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign wr_second = wr_reg + PTR_W'(1);

    always_comb begin
        wr_next    = wr_reg + PTR_W'(push.cnt);
        rd_next    = pop ? rd_reg + PTR_W'(1) : rd_reg;
        level_next = level_reg + LEVEL_W'(push.cnt) - LEVEL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_second] <= push.res1;
        end
    end

endmodule

### src/sorted_interval_cluster_merge_unit.sv
// ----------------------------------------------------------------------------
// sorted_interval_cluster_merge_unit
// Merges start-sorted partial alignments into clusters and reports each one.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one partial alignment per request, sorted by
//   ref_start. m_valid/m_ready/m_data carry one closed cluster per request.
//   cfg_valid/cfg_ready/cfg_data write min_trigger_len; write it only while
//   no request is in flight.
// Path: an accepted item waits in the input register until the result queue
//   has room for two results; its results are then written into the queue,
//   from which m_valid is driven.
// Throughput: one item per cycle while each item yields at most one result
//   and m_ready is high. An item that both closes a cluster and ends the
//   stream yields two, which the single output port delivers in turn. The
//   four-entry result queue sets how far the input runs ahead of the output.
// Stall: when m_ready stays low the queue level rises past two and s_ready
//   drops; nothing is dropped. Reset clears the open cluster, the item index,
//   the queue and min_trigger_len; the block takes items once it is released.
// ----------------------------------------------------------------------------
module sorted_interval_cluster_merge_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sicm_pkg::item_t               s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sicm_pkg::result_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sicm_pkg::THR_W-1:0]    cfg_data
);
    import sicm_pkg::*;

    logic [THR_W-1:0]   thr_reg;
    push_t              push;
    logic               room;
    logic [LEVEL_W-1:0] level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    sicm_cluster_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_data         (s_data),
        .min_trigger_len (thr_reg),
        .room            (room),
        .push            (push)
    );

    sicm_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .level     (level),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef SYNTH
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= LEVEL_W'(FIFO_DEPTH))
        else $error("result queue level above depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt != 2'd0) |-> (level <= LEVEL_W'(FIFO_DEPTH - 2)))
        else $error("results pushed without room for two");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt == 2'd0 && m_valid && m_ready) |=> (level == $past(level) - LEVEL_W'(1)))
        else $error("queue level not decremented on pop");
`endif

endmodule
